// ===== hw/rtl/demand_window_peak_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the demand window peak tracker
// Implication checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef DEMAND_WINDOW_PEAK_TRACKER_CORE_MACROS_SVH
`define DEMAND_WINDOW_PEAK_TRACKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define DWPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define DWPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define DWPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define DWPT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/dwpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Demand window peak tracker package
// Field widths, sizing constants, operation and channel codes, pipeline tag.
// ----------------------------------------------------------------------------
package dwpt_pkg;

   // sizing
   localparam int WINDOW_LENGTH = 15;
   localparam int NUM_BUSES     = 2;
   localparam int CHANNELS      = 7;

   // transfer field widths
   localparam int OP_W   = 1;
   localparam int BUS_W  = 1;
   localparam int CUR_W  = 16;
   localparam int PWR_W  = 24;
   localparam int CHAN_W = 3;
   localparam int AVG_W  = 24;
   localparam int PEAK_W = 23;

   // internal widths
   localparam int SUM_W     = 28;
   localparam int MAG_W     = SUM_W;
   localparam int MEM_DEPTH = NUM_BUSES * CHANNELS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int BUS_IDX_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
   localparam int CNT_W     = $clog2(WINDOW_LENGTH + 1);

   // divide by window length: multiply by floor(2^SHIFT / N), one correction step
   localparam int RECIP_SHIFT = MAG_W;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WINDOW_LENGTH;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam int REM_W       = $clog2(2 * WINDOW_LENGTH);

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // channel codes
   localparam logic [CHAN_W-1:0] CH_CUR_A = 3'd0;
   localparam logic [CHAN_W-1:0] CH_CUR_B = 3'd1;
   localparam logic [CHAN_W-1:0] CH_CUR_C = 3'd2;
   localparam logic [CHAN_W-1:0] CH_PWR_A = 3'd3;
   localparam logic [CHAN_W-1:0] CH_PWR_B = 3'd4;
   localparam logic [CHAN_W-1:0] CH_PWR_C = 3'd5;
   localparam logic [CHAN_W-1:0] CH_PWR_T = 3'd6;
   localparam logic [CHAN_W-1:0] CH_LAST  = CH_PWR_T;

   // tag carried down the pipeline with each channel
   typedef struct packed {
      logic [BUS_W-1:0]  bus;
      logic [CHAN_W-1:0] chan;
      logic [ADDR_W-1:0] addr;
   } tag_type;

endpackage

// ===== hw/rtl/dwpt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module dwpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/demand_window_peak_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Demand window peak tracker core
// Per-bus block demand averaging with maximum demand over seven channels.
//
// req_ channel: one minute record (three currents, four powers) per transfer,
// or a clear operation that zeroes every window sum and peak demand.
// rsp_ channel: when a bus completes its window of WINDOW_LENGTH records,
// seven transfers follow, channels 0..6, rsp_last on the seventh, each with
// the truncated window average and the updated peak demand.
// Throughput: one channel a cycle unless rsp_stall holds the pipeline, via the
// single read port of the window sum memory; a record enters as the last one's
// final channel issues. Results pass hold, stage 1..4 and output registers.
// A clear waits until the arithmetic pipeline has drained.
// Reset (synchronous) empties the pipeline and marks every sum, peak and
// window count as zero at once; no clearing pass is needed.
// rsp_stall freezes the whole pipeline with the pending result held; one
// further record can still be taken into an empty input register meanwhile.
// ----------------------------------------------------------------------------
`include "demand_window_peak_tracker_core_macros.svh"

module demand_window_peak_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dwpt_pkg::OP_W-1:0]           req_operation,
   input  logic [dwpt_pkg::BUS_W-1:0]          req_bus,
   input  logic [dwpt_pkg::CUR_W-1:0]          req_current_a,
   input  logic [dwpt_pkg::CUR_W-1:0]          req_current_b,
   input  logic [dwpt_pkg::CUR_W-1:0]          req_current_c,
   input  logic signed [dwpt_pkg::PWR_W-1:0]   req_power_a,
   input  logic signed [dwpt_pkg::PWR_W-1:0]   req_power_b,
   input  logic signed [dwpt_pkg::PWR_W-1:0]   req_power_c,
   input  logic signed [dwpt_pkg::PWR_W-1:0]   req_power_total,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dwpt_pkg::BUS_W-1:0]          rsp_result_bus,
   output logic [dwpt_pkg::CHAN_W-1:0]         rsp_channel,
   output logic signed [dwpt_pkg::AVG_W-1:0]   rsp_window_average,
   output logic [dwpt_pkg::PEAK_W-1:0]         rsp_peak_demand,
   output logic                                rsp_last
);

   import dwpt_pkg::*;

   // ------------------------------------------------------------------------
   // declarations
   // ------------------------------------------------------------------------
   logic adv, is_clear, bus_ok, pipe_empty, clr_go, drop, step, step_last;
   logic hold_done, req_xfer;

   logic                 hold_valid_ff, hold_valid_in;
   logic [OP_W-1:0]      hold_op_ff;
   logic [BUS_W-1:0]     hold_bus_ff;
   logic [CUR_W-1:0]     hold_cur_ff [3];
   logic [PWR_W-1:0]     hold_pwr_ff [4];
   logic [CHAN_W-1:0]    k_ff, k_in;
   logic                 close_ff, close_in;

   logic [CNT_W-1:0]     cnt_ff [NUM_BUSES];
   logic [CNT_W-1:0]     cnt_in [NUM_BUSES];
   logic [BUS_IDX_W-1:0] bus_idx;
   logic                 cnt_hit, close_now;
   logic [ADDR_W-1:0]    issue_addr;
   logic signed [SUM_W-1:0] sample;

   logic [MEM_DEPTH-1:0] sum_vld_ff, sum_vld_in;
   logic [MEM_DEPTH-1:0] peak_vld_ff, peak_vld_in;

   logic [SUM_W-1:0]     sum_rd_data;
   logic [PEAK_W-1:0]    peak_rd_data;
   logic                 sum_wr_en, peak_wr_en;
   logic [SUM_W-1:0]     sum_wr_data;

   // stage 1: accumulate
   logic                 s1_valid_ff, s1_valid_in;
   tag_type              s1_tag_ff, s1_tag_in;
   logic                 s1_close_ff;
   logic signed [SUM_W-1:0] s1_sample_ff;
   logic                 s1_sum_vld_ff, s1_peak_vld_ff;
   logic signed [SUM_W-1:0] sum_old;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_new;

   // stage 2: magnitude and reciprocal multiply
   logic                 s2_valid_ff, s2_valid_in;
   tag_type              s2_tag_ff;
   logic signed [SUM_W-1:0] s2_sum_ff;
   logic [PEAK_W-1:0]    s2_peak_ff;
   logic [MAG_W-1:0]     s2_mag;
   logic [PROD_W-1:0]    s2_prod;

   // stage 3: quotient estimate and remainder
   logic                 s3_valid_ff, s3_valid_in;
   tag_type              s3_tag_ff;
   logic                 s3_neg_ff;
   logic [MAG_W-1:0]     s3_mag_ff;
   logic [PROD_W-1:0]    s3_prod_ff;
   logic [PEAK_W-1:0]    s3_peak_ff;
   logic [MAG_W-1:0]     s3_q0;
   logic [MAG_W-1:0]     s3_rem_full;

   // stage 4: correction, sign, saturation, peak update
   logic                 s4_valid_ff, s4_valid_in;
   tag_type              s4_tag_ff;
   logic                 s4_neg_ff;
   logic [MAG_W-1:0]     s4_q0_ff;
   logic [REM_W-1:0]     s4_rem_ff;
   logic [PEAK_W-1:0]    s4_peak_ff;
   logic [MAG_W-1:0]     s4_q;
   logic signed [MAG_W:0]   avg_full;
   logic [MAG_W-AVG_W+1:0]  avg_top;
   logic signed [AVG_W-1:0] avg;
   logic [PEAK_W-1:0]    peak_new;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [BUS_W-1:0]     out_bus_ff;
   logic [CHAN_W-1:0]    out_chan_ff;
   logic signed [AVG_W-1:0] out_avg_ff;
   logic [PEAK_W-1:0]    out_peak_ff;
   logic                 out_last_ff;

   // ------------------------------------------------------------------------
   // sequencer control
   // ------------------------------------------------------------------------
   assign adv        = !out_valid_ff || !rsp_stall;
   assign is_clear   = (op_type'(hold_op_ff) == OP_CLEAR);
   assign bus_ok     = (32'(hold_bus_ff) < NUM_BUSES);
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !s4_valid_ff;
   assign clr_go     = hold_valid_ff && is_clear && pipe_empty;
   assign drop       = hold_valid_ff && !is_clear && !bus_ok;
   assign step       = hold_valid_ff && !is_clear && bus_ok && adv;
   assign step_last  = step && (k_ff == CH_LAST);
   assign hold_done  = clr_go || drop || step_last;

   assign req_stall  = hold_valid_ff && !hold_done;
   assign req_xfer   = req_valid && !req_stall;

   assign bus_idx    = BUS_IDX_W'(hold_bus_ff);
   assign cnt_hit    = (cnt_ff[bus_idx] == CNT_W'(WINDOW_LENGTH - 1));
   assign close_now  = (k_ff == CH_CUR_A) ? cnt_hit : close_ff;
   assign issue_addr = ADDR_W'(bus_idx) * ADDR_W'(CHANNELS) + ADDR_W'(k_ff);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_xfer) begin
         hold_valid_in = 1'b1;
      end else if (hold_done) begin
         hold_valid_in = 1'b0;
      end

      k_in     = k_ff;
      close_in = close_ff;
      if (step) begin
         k_in     = step_last ? CH_CUR_A : k_ff + CHAN_W'(1);
         close_in = close_now;
      end

      // window count advances on the first channel of each record
      cnt_in = cnt_ff;
      if (step && (k_ff == CH_CUR_A)) begin
         cnt_in[bus_idx] = cnt_hit ? '0 : cnt_ff[bus_idx] + CNT_W'(1);
      end
   end

   // channel sample, widened to the sum width
   always_comb begin
      case (k_ff)
         CH_CUR_A: sample = SUM_W'(hold_cur_ff[0]);
         CH_CUR_B: sample = SUM_W'(hold_cur_ff[1]);
         CH_CUR_C: sample = SUM_W'(hold_cur_ff[2]);
         CH_PWR_A: sample = SUM_W'($signed(hold_pwr_ff[0]));
         CH_PWR_B: sample = SUM_W'($signed(hold_pwr_ff[1]));
         CH_PWR_C: sample = SUM_W'($signed(hold_pwr_ff[2]));
         CH_PWR_T: sample = SUM_W'($signed(hold_pwr_ff[3]));
         default:  sample = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // state memories
   // ------------------------------------------------------------------------
   dwpt_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MEM_DEPTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (s1_tag_ff.addr),
      .wr_data (sum_wr_data),
      .rd_en   (step),
      .rd_addr (issue_addr),
      .rd_data (sum_rd_data)
   );

   dwpt_ram #(
      .WIDTH (PEAK_W),
      .DEPTH (MEM_DEPTH)
   ) u_peak_ram (
      .clock   (clock),
      .wr_en   (peak_wr_en),
      .wr_addr (s4_tag_ff.addr),
      .wr_data (peak_new),
      .rd_en   (step),
      .rd_addr (issue_addr),
      .rd_data (peak_rd_data)
   );

   // ------------------------------------------------------------------------
   // stage 1: saturating accumulate, write back (zero when the window closes)
   // ------------------------------------------------------------------------
   always_comb begin
      s1_tag_in.bus  = hold_bus_ff;
      s1_tag_in.chan = k_ff;
      s1_tag_in.addr = issue_addr;
   end

   assign sum_old  = s1_sum_vld_ff ? $signed(sum_rd_data) : '0;
   assign sum_wide = {sum_old[SUM_W-1], sum_old} + {s1_sample_ff[SUM_W-1], s1_sample_ff};

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_new = sum_wide[SUM_W-1:0];
      end
   end

   assign sum_wr_en   = s1_valid_ff && adv;
   assign sum_wr_data = s1_close_ff ? '0 : sum_new;

   // ------------------------------------------------------------------------
   // stage 2: magnitude times reciprocal of the window length
   // ------------------------------------------------------------------------
   assign s2_mag  = s2_sum_ff[SUM_W-1] ? MAG_W'(-s2_sum_ff) : MAG_W'(s2_sum_ff);
   assign s2_prod = PROD_W'(s2_mag) * PROD_W'(RECIP);

   // ------------------------------------------------------------------------
   // stage 3: quotient estimate (low by at most one) and its remainder
   // ------------------------------------------------------------------------
   assign s3_q0       = MAG_W'(s3_prod_ff >> RECIP_SHIFT);
   assign s3_rem_full = s3_mag_ff - MAG_W'(s3_q0 * MAG_W'(WINDOW_LENGTH));

   // ------------------------------------------------------------------------
   // stage 4: correct, restore sign, saturate, update peak demand
   // ------------------------------------------------------------------------
   assign s4_q     = s4_q0_ff + MAG_W'(s4_rem_ff >= REM_W'(WINDOW_LENGTH));
   assign avg_full = s4_neg_ff ? -$signed({1'b0, s4_q}) : $signed({1'b0, s4_q});
   assign avg_top  = avg_full[MAG_W:AVG_W-1];

   always_comb begin
      if ((&avg_top) || !(|avg_top)) begin
         avg = avg_full[AVG_W-1:0];
      end else begin
         avg = avg_full[MAG_W] ? {1'b1, {(AVG_W-1){1'b0}}} : {1'b0, {(AVG_W-1){1'b1}}};
      end
      // a positive average never exceeds the peak range
      peak_new = (avg > $signed({1'b0, s4_peak_ff})) ? PEAK_W'(avg) : s4_peak_ff;
   end

   assign peak_wr_en = s4_valid_ff && adv;

   // ------------------------------------------------------------------------
   // stage valids and entry valid bits
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      s3_valid_in  = s3_valid_ff;
      s4_valid_in  = s4_valid_ff;
      out_valid_in = out_valid_ff;
      if (adv) begin
         s1_valid_in  = step;
         s2_valid_in  = s1_valid_ff && s1_close_ff;
         s3_valid_in  = s2_valid_ff;
         s4_valid_in  = s3_valid_ff;
         out_valid_in = s4_valid_ff;
      end

      sum_vld_in  = sum_vld_ff;
      peak_vld_in = peak_vld_ff;
      if (clr_go) begin
         sum_vld_in  = '0;
         peak_vld_in = '0;
      end
      if (sum_wr_en) begin
         sum_vld_in[s1_tag_ff.addr] = 1'b1;
      end
      if (peak_wr_en) begin
         peak_vld_in[s4_tag_ff.addr] = 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         k_ff          <= CH_CUR_A;
         close_ff      <= 1'b0;
         for (int i = 0; i < NUM_BUSES; i++) begin
            cnt_ff[i] <= '0;
         end
         sum_vld_ff    <= '0;
         peak_vld_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         k_ff          <= k_in;
         close_ff      <= close_in;
         cnt_ff        <= cnt_in;
         sum_vld_ff    <= sum_vld_in;
         peak_vld_ff   <= peak_vld_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
         s4_valid_ff   <= s4_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         hold_op_ff     <= req_operation;
         hold_bus_ff    <= req_bus;
         hold_cur_ff[0] <= req_current_a;
         hold_cur_ff[1] <= req_current_b;
         hold_cur_ff[2] <= req_current_c;
         hold_pwr_ff[0] <= req_power_a;
         hold_pwr_ff[1] <= req_power_b;
         hold_pwr_ff[2] <= req_power_c;
         hold_pwr_ff[3] <= req_power_total;
      end
      if (adv) begin
         s1_tag_ff      <= s1_tag_in;
         s1_close_ff    <= close_now;
         s1_sample_ff   <= sample;
         s1_sum_vld_ff  <= sum_vld_ff[issue_addr];
         s1_peak_vld_ff <= peak_vld_ff[issue_addr];

         s2_tag_ff      <= s1_tag_ff;
         s2_sum_ff      <= sum_new;
         s2_peak_ff     <= s1_peak_vld_ff ? peak_rd_data : '0;

         s3_tag_ff      <= s2_tag_ff;
         s3_neg_ff      <= s2_sum_ff[SUM_W-1];
         s3_mag_ff      <= s2_mag;
         s3_prod_ff     <= s2_prod;
         s3_peak_ff     <= s2_peak_ff;

         s4_tag_ff      <= s3_tag_ff;
         s4_neg_ff      <= s3_neg_ff;
         s4_q0_ff       <= s3_q0;
         s4_rem_ff      <= REM_W'(s3_rem_full);
         s4_peak_ff     <= s3_peak_ff;

         out_bus_ff     <= s4_tag_ff.bus;
         out_chan_ff    <= s4_tag_ff.chan;
         out_avg_ff     <= avg;
         out_peak_ff    <= peak_new;
         out_last_ff    <= (s4_tag_ff.chan == CH_LAST);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_bus     = out_bus_ff;
   assign rsp_channel        = out_chan_ff;
   assign rsp_window_average = out_avg_ff;
   assign rsp_peak_demand    = out_peak_ff;
   assign rsp_last           = out_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // a run of seven results leaves without gaps, channel by channel
   `DWPT_ASSERT_NXT(a_run_unbroken, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && (rsp_channel == $past(rsp_channel) + CHAN_W'(1)))
   // reported peak is never below a positive average
   `DWPT_ASSERT_IMP(a_peak_covers_avg, clock, reset, rsp_valid, rsp_window_average[AVG_W-1] || (PEAK_W'(rsp_window_average) <= rsp_peak_demand))
   // no read of an entry whose sum or peak write back is still pending
   `DWPT_ASSERT_IMP(a_no_rmw_overlap, clock, reset, step, (!s1_valid_ff || (s1_tag_ff.addr != issue_addr)) && (!s4_valid_ff || (s4_tag_ff.addr != issue_addr)))

endmodule
